// ----- design/lecr_pkg.sv -----
// ----------------------------------------------------------------------------
// lecr_pkg - shared definitions for the line edit command receiver
// Byte classes, command codes, character constants and the queue item type.
// ----------------------------------------------------------------------------
package lecr_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int POS_W         = $clog2(LINE_CAPACITY + 1);
    localparam int LEN_W         = 6;
    localparam int CMD_W         = 3;
    // only the first five characters ever decide the command
    localparam int HEAD_N        = 5;

    localparam logic [7:0] KEY_BACKSPACE = 8'd127;
    localparam logic [7:0] KEY_LF        = 8'd10;
    localparam logic [7:0] KEY_CR        = 8'd13;

    localparam logic [CMD_W-1:0] CMD_HELP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ON      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OFF     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TEMP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        K_CHAR,
        K_BACKSPACE,
        K_LF,
        K_CR
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

endpackage

// ----- design/lecr_front.sv -----
// ----------------------------------------------------------------------------
// lecr_front - byte intake
// Classifies each received byte and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module lecr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_rx_byte,
    output logic             o_item_valid,
    input  logic             i_item_ready,
    output lecr_pkg::t_item  o_item
);

    lecr_pkg::t_item r_entry [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_count,  n_count;
    lecr_pkg::t_item w_item;
    logic            w_push, w_pop;

    always_comb begin
        w_item.data = i_rx_byte;
        if (i_rx_byte == lecr_pkg::KEY_BACKSPACE) begin
            w_item.kind = lecr_pkg::K_BACKSPACE;
        end else if (i_rx_byte == lecr_pkg::KEY_LF) begin
            w_item.kind = lecr_pkg::K_LF;
        end else if (i_rx_byte == lecr_pkg::KEY_CR) begin
            w_item.kind = lecr_pkg::K_CR;
        end else begin
            w_item.kind = lecr_pkg::K_CHAR;
        end
    end

    assign o_ready      = (r_count != 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_entry[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_item_valid && i_item_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ----- design/lecr_back.sv -----
// ----------------------------------------------------------------------------
// lecr_back - line editing and command match
// Keeps the write position and the head of the line, edits it per byte,
// matches completed lines and registers one result per byte.
// ----------------------------------------------------------------------------
module lecr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  lecr_pkg::t_item               i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_echo_valid,
    output logic [7:0]                    o_echo_byte,
    output logic                          o_line_done,
    output logic [lecr_pkg::CMD_W-1:0]    o_command,
    output logic [lecr_pkg::LEN_W-1:0]    o_line_length
);

    localparam logic [lecr_pkg::POS_W-1:0] CAP =
        lecr_pkg::POS_W'(lecr_pkg::LINE_CAPACITY);

    logic [lecr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_head [lecr_pkg::HEAD_N];
    logic [7:0]                 w_head [lecr_pkg::HEAD_N];
    logic [lecr_pkg::POS_W-1:0] w_p0, w_p1;
    logic                       w_take, w_store, w_done;
    logic [lecr_pkg::HEAD_N-1:0] w_nz;
    logic [lecr_pkg::CMD_W-1:0] w_cmd;

    logic                       r_valid;
    logic                       r_echo_valid;
    logic [7:0]                 r_echo_byte;
    logic                       r_line_done;
    logic [lecr_pkg::CMD_W-1:0] r_command;
    logic [lecr_pkg::LEN_W-1:0] r_line_length;

    assign o_item_ready = !r_valid || i_ready;
    assign w_take       = i_item_valid && o_item_ready;

    always_comb begin
        // full store wraps before the byte is handled
        w_p0    = (r_pos == CAP) ? '0 : r_pos;
        w_store = (i_item.kind == lecr_pkg::K_CHAR);
        w_p1    = w_p0;
        if (i_item.kind == lecr_pkg::K_BACKSPACE) begin
            if (w_p0 != '0) begin
                w_p1 = w_p0 - lecr_pkg::POS_W'(1);
            end
        end else if (w_store) begin
            w_p1 = w_p0 + lecr_pkg::POS_W'(1);
        end
        w_done = (i_item.kind == lecr_pkg::K_CR) ||
                 ((i_item.kind == lecr_pkg::K_LF) && (w_p1 != '0));
        n_pos  = w_done ? '0 : w_p1;
    end

    always_comb begin
        for (int i = 0; i < lecr_pkg::HEAD_N; i++) begin
            w_head[i] = (w_store && (w_p0 == lecr_pkg::POS_W'(i))) ?
                        i_item.data : r_head[i];
            w_nz[i]   = (lecr_pkg::POS_W'(i) < w_p1) && (w_head[i] != 8'd0);
        end
    end

    // string compare ends at the first zero byte
    always_comb begin
        if (w_nz[3:0] == 4'b1111 && !w_nz[4] && w_head[0] == "h" &&
            w_head[1] == "e" && w_head[2] == "l" && w_head[3] == "p") begin
            w_cmd = lecr_pkg::CMD_HELP;
        end else if (w_nz[1:0] == 2'b11 && !w_nz[2] &&
                     w_head[0] == "o" && w_head[1] == "n") begin
            w_cmd = lecr_pkg::CMD_ON;
        end else if (w_nz[2:0] == 3'b111 && !w_nz[3] && w_head[0] == "o" &&
                     w_head[1] == "f" && w_head[2] == "f") begin
            w_cmd = lecr_pkg::CMD_OFF;
        end else if (w_nz[3:0] == 4'b1111 && !w_nz[4] && w_head[0] == "t" &&
                     w_head[1] == "e" && w_head[2] == "m" && w_head[3] == "p") begin
            w_cmd = lecr_pkg::CMD_TEMP;
        end else begin
            w_cmd = lecr_pkg::CMD_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_pos <= n_pos;
            end
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int i = 0; i < lecr_pkg::HEAD_N; i++) begin
                r_head[i] <= w_head[i];
            end
            r_echo_valid  <= (i_item.kind != lecr_pkg::K_LF);
            r_echo_byte   <= i_item.data;
            r_line_done   <= w_done;
            r_command     <= w_done ? w_cmd : lecr_pkg::CMD_HELP;
            r_line_length <= w_done ? w_p1[lecr_pkg::LEN_W-1:0] : '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_echo_valid  = r_echo_valid;
    assign o_echo_byte   = r_echo_byte;
    assign o_line_done   = r_line_done;
    assign o_command     = r_command;
    assign o_line_length = r_line_length;

endmodule

// ----- design/line_edit_command_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// line_edit_command_receiver_unit - serial console line editor
// Path: a byte accepted into the queue entry has its result written to the
// result register in the editing stage once that stage takes it.
// Throughput: one byte per cycle unless the output stalls, set by the back
// stage's combinational edit and match; the two-entry queue absorbs stalls.
// Reset: synchronous, active low; clears the queue, the result valid and
// the write position. Stored characters are not cleared.
// ----------------------------------------------------------------------------
module line_edit_command_receiver_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_echo_valid,
    output logic [7:0]                    o_echo_byte,
    output logic                          o_line_done,
    output logic [lecr_pkg::CMD_W-1:0]    o_command,
    output logic [lecr_pkg::LEN_W-1:0]    o_line_length
);

    logic            w_item_valid;
    logic            w_item_ready;
    lecr_pkg::t_item w_item;

    lecr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    lecr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .o_item_ready  (w_item_ready),
        .i_item        (w_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_echo_valid  (o_echo_valid),
        .o_echo_byte   (o_echo_byte),
        .o_line_done   (o_line_done),
        .o_command     (o_command),
        .o_line_length (o_line_length)
    );

    // idle result fields stay zero
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_line_done) |-> (o_command == lecr_pkg::CMD_HELP &&
                                       o_line_length == '0))
        else $error("result fields not cleared without line completion");

    // only CR or LF completes a line
    a_done_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_done) |->
            (o_echo_byte == lecr_pkg::KEY_CR || o_echo_byte == lecr_pkg::KEY_LF))
        else $error("line completed by a byte other than CR or LF");

    // queue is empty right after reset
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (o_ready && !w_item_valid))
        else $error("queue not empty after reset");

    // a queued item moves whenever the result register is free
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_valid && !o_valid) |=> o_valid)
        else $error("queued byte not taken by the editing stage");

endmodule
